// File: rtl/fbpa_pkg.sv
package fbpa_pkg;

  localparam int CNT_W       = 11;
  localparam int BSIZE_W     = 17;
  localparam int FIELD_AW    = 32;
  localparam int IDX_OUT_W   = 10;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = 2;

  // Register indexes; byte address is four times the index.
  localparam logic [REG_IDX_W-1:0] REG_BLK_BYTES    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_POOL_BLOCKS  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd2;

  localparam logic [BSIZE_W-1:0] BLK_BYTES_RST   = 17'd64;
  localparam logic [CNT_W-1:0]   POOL_BLOCKS_RST = 11'd1024;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic load;
    logic lazy;
    logic rd;
    logic div_start;
    logic commit;
  } fbpa_cmd_t;

  typedef struct packed {
    logic div_busy;
  } fbpa_sts_t;

  typedef struct packed {
    logic                  we;
    logic [REG_IDX_W-1:0]  idx;
    logic [APB_DATA_W-1:0] wdata;
  } fbpa_cfg_t;

endpackage

// File: rtl/fixed_block_pool_allocator.sv
// Allocate: the steps are link write, link read and commit (states LAZY, RD, CMT);
// the lazy link write and the head read use the link memory in separate states.
// Free: the index comes from the bit-serial divider, then the result is committed.
// One item is in progress at a time; the next word is taken while a result waits.
// Reset is asynchronous, active low; the link memory is not cleared, since lazy
// initialization writes each entry before it is read.
module fixed_block_pool_allocator #(
  parameter int DEPTH     = 1024,
  parameter int ADDR_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 kind_i,
  input  logic [fbpa_pkg::FIELD_AW-1:0]        free_address_i,

  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 status_o,
  output logic [fbpa_pkg::FIELD_AW-1:0]        block_address_o,
  output logic [fbpa_pkg::IDX_OUT_W-1:0]       block_index_o,
  output logic [fbpa_pkg::CNT_W-1:0]           free_blocks_o,

  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fbpa_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [fbpa_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [fbpa_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  fbpa_pkg::fbpa_cmd_t cmd;
  fbpa_pkg::fbpa_sts_t sts;
  fbpa_pkg::fbpa_cfg_t cfg;

  assign pready    = 1'b1;
  assign cfg.we    = psel && penable && pwrite;
  assign cfg.idx   = paddr[fbpa_pkg::APB_ADDR_W-1:2];
  assign cfg.wdata = pwdata;

  fbpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fbpa_dp #(
    .DEPTH     (DEPTH),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (kind_i),
    .free_address_i  (free_address_i),
    .cfg_i           (cfg),
    .prdata_o        (prdata),
    .status_o        (status_o),
    .block_address_o (block_address_o),
    .block_index_o   (block_index_o),
    .free_blocks_o   (free_blocks_o)
  );

endmodule

// File: rtl/fbpa_div.sv
module fbpa_div #(
  parameter int W = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [W-1:0]                    dividend_i,
  input  logic [fbpa_pkg::BSIZE_W-1:0]    divisor_i,
  output logic                            busy_o,
  output logic [W-1:0]                    quotient_o
);

  localparam int BW  = fbpa_pkg::BSIZE_W;
  localparam int CTW = $clog2(W + 1);

  logic           busy_q;
  logic [CTW-1:0] cnt_q;
  logic [W-1:0]   quo_q;
  logic [BW-1:0]  rem_q;
  logic [BW:0]    trial;
  logic [BW:0]    diff;
  logic           ge;

  // Restoring division, one quotient bit per cycle, dividend shifted out of quo_q.
  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    diff  = trial - {1'b0, divisor_i};
    ge    = (trial >= {1'b0, divisor_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CTW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CTW'(1);
      if (cnt_q == CTW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[W-2:0], ge};
      rem_q <= ge ? diff[BW-1:0] : trial[BW-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/fbpa_dp.sv
module fbpa_dp #(
  parameter int DEPTH     = 1024,
  parameter int ADDR_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fbpa_pkg::fbpa_cmd_t                cmd_i,
  output fbpa_pkg::fbpa_sts_t                sts_o,
  input  logic                               kind_i,
  input  logic [fbpa_pkg::FIELD_AW-1:0]      free_address_i,
  input  fbpa_pkg::fbpa_cfg_t                cfg_i,
  output logic [fbpa_pkg::APB_DATA_W-1:0]    prdata_o,
  output logic                               status_o,
  output logic [fbpa_pkg::FIELD_AW-1:0]      block_address_o,
  output logic [fbpa_pkg::IDX_OUT_W-1:0]     block_index_o,
  output logic [fbpa_pkg::CNT_W-1:0]         free_blocks_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = fbpa_pkg::CNT_W;
  localparam int BW = fbpa_pkg::BSIZE_W;
  localparam int AW = ADDR_BITS;
  localparam int FW = fbpa_pkg::FIELD_AW;
  localparam int OW = fbpa_pkg::IDX_OUT_W;
  localparam int DW = fbpa_pkg::APB_DATA_W;
  localparam int PoolRstUse = (int'(fbpa_pkg::POOL_BLOCKS_RST) < DEPTH) ?
                              int'(fbpa_pkg::POOL_BLOCKS_RST) : DEPTH;

  // Configuration registers.
  logic [BW-1:0] bsize_q;
  logic [CW-1:0] pool_q;
  logic [FW-1:0] base_q;

  // Pool state.
  logic [CW-1:0] head_q;
  logic [CW-1:0] init_q;
  logic [CW-1:0] free_q;

  // Item payload and intermediate values.
  logic             kind_q;
  logic [FW-1:0]    faddr_q;
  logic [CW+BW-1:0] prod_q;
  logic [CW-1:0]    rd_q;

  logic [CW-1:0] link_mem [DEPTH];

  logic [CW-1:0] pool_use;
  logic [CW-1:0] new_pool;
  logic [CW-1:0] new_pool_use;
  logic [BW-1:0] size_use;
  logic          lazy_go;
  logic          head_oob;
  logic [CW-1:0] link_use;
  logic [AW-1:0] dividend;
  logic [AW-1:0] quo;
  logic          div_busy;
  logic          free_ok;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [CW-1:0] mem_wd;
  logic [AW-1:0] addr_full;

  logic          status_d;
  logic [FW-1:0] addr_d;
  logic [OW-1:0] idx_d;
  logic [CW-1:0] free_out_d;

  always_comb begin
    pool_use     = (32'(pool_q) < DEPTH) ? pool_q : CW'(DEPTH);
    new_pool     = cfg_i.wdata[CW-1:0];
    new_pool_use = (32'(new_pool) < DEPTH) ? new_pool : CW'(DEPTH);
    size_use     = (bsize_q == '0) ? BW'(1) : bsize_q;
    lazy_go      = cmd_i.lazy && (init_q < pool_use);
    head_oob     = (32'(head_q) >= DEPTH);
    link_use     = head_oob ? pool_use : rd_q;
    dividend     = AW'(faddr_q) - AW'(base_q);
    free_ok      = (quo < AW'(pool_use)) && (free_q < pool_use);
    addr_full    = AW'(base_q) + AW'(prod_q);
  end

  fbpa_div #(
    .W (AW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (size_use),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  assign sts_o.div_busy = div_busy;

  // One write port shared by lazy linking and by freeing.
  always_comb begin
    mem_we = lazy_go || (cmd_i.commit && (kind_q == fbpa_pkg::KIND_FREE) && free_ok);
    if (cmd_i.lazy) begin
      mem_wa = IW'(init_q);
      mem_wd = init_q + CW'(1);
    end else begin
      mem_wa = quo[IW-1:0];
      mem_wd = (free_q != '0) ? head_q : pool_use;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.rd) begin
      rd_q <= link_mem[IW'(head_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q <= fbpa_pkg::BLK_BYTES_RST;
      pool_q  <= fbpa_pkg::POOL_BLOCKS_RST;
      base_q  <= '0;
      head_q  <= '0;
      init_q  <= '0;
      free_q  <= CW'(PoolRstUse);
    end else begin
      if (cfg_i.we) begin
        unique case (cfg_i.idx)
          fbpa_pkg::REG_BLK_BYTES: begin
            bsize_q <= cfg_i.wdata[BW-1:0];
          end
          fbpa_pkg::REG_POOL_BLOCKS: begin
            pool_q <= new_pool;
            head_q <= '0;
            init_q <= '0;
            free_q <= new_pool_use;
          end
          fbpa_pkg::REG_BASE_ADDRESS: begin
            base_q <= cfg_i.wdata[FW-1:0];
          end
          default: begin
          end
        endcase
      end
      if (lazy_go) begin
        init_q <= init_q + CW'(1);
      end
      if (cmd_i.commit) begin
        if (kind_q == fbpa_pkg::KIND_ALLOC) begin
          if (free_q != '0) begin
            free_q <= free_q - CW'(1);
            // The last block out leaves the head at the end marker.
            head_q <= (free_q == CW'(1)) ? pool_use : link_use;
          end
        end else if (free_ok) begin
          head_q <= quo[CW-1:0];
          free_q <= free_q + CW'(1);
        end
      end
    end
  end

  always_comb begin
    if (kind_q == fbpa_pkg::KIND_ALLOC) begin
      if (free_q != '0) begin
        status_d   = fbpa_pkg::STATUS_OK;
        addr_d     = FW'(addr_full);
        idx_d      = head_q[OW-1:0];
        free_out_d = free_q - CW'(1);
      end else begin
        status_d   = fbpa_pkg::STATUS_EMPTY;
        addr_d     = '0;
        idx_d      = '0;
        free_out_d = free_q;
      end
    end else begin
      status_d   = fbpa_pkg::STATUS_OK;
      addr_d     = '0;
      idx_d      = quo[OW-1:0];
      free_out_d = free_ok ? (free_q + CW'(1)) : free_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      faddr_q <= free_address_i;
    end
    if (cmd_i.lazy) begin
      prod_q <= (CW+BW)'(head_q) * (CW+BW)'(size_use);
    end
    if (cmd_i.commit) begin
      status_o        <= status_d;
      block_address_o <= addr_d;
      block_index_o   <= idx_d;
      free_blocks_o   <= free_out_d;
    end
  end

  always_comb begin
    unique case (cfg_i.idx)
      fbpa_pkg::REG_BLK_BYTES:    prdata_o = DW'(bsize_q);
      fbpa_pkg::REG_POOL_BLOCKS:  prdata_o = DW'(pool_q);
      fbpa_pkg::REG_BASE_ADDRESS: prdata_o = DW'(base_q);
      default:                    prdata_o = '0;
    endcase
  end

endmodule

// File: rtl/fbpa_ctrl.sv
module fbpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 kind_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  input  fbpa_pkg::fbpa_sts_t  sts_i,
  output fbpa_pkg::fbpa_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAZY,
    S_RD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_CMT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  // The output word may be replaced in the same cycle it is taken.
  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.lazy      = (state_q == S_LAZY);
    cmd_o.rd        = (state_q == S_RD);
    cmd_o.div_start = (state_q == S_DIV_GO);
    cmd_o.commit    = (state_q == S_CMT) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= (kind_i == fbpa_pkg::KIND_FREE) ? S_DIV_GO : S_LAZY;
          end
        end
        S_LAZY:   state_q <= S_RD;
        S_RD:     state_q <= S_CMT;
        S_DIV_GO: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (!sts_i.div_busy) begin
            state_q <= S_CMT;
          end
        end
        S_CMT: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("committed result not presented");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("new word taken while an item is in progress");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command at once");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> sts_i.div_busy)
    else $error("divider did not start");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !cmd_o.commit)
    else $error("pending result overwritten");

endmodule

// File: dv/tb.sv
module tb;

  localparam int POOL_DEPTH  = 1024;
  localparam int BLK_IDX_W   = $clog2(POOL_DEPTH);
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic                           status;
    logic [fbpa_pkg::FIELD_AW-1:0]  addr;
    logic [fbpa_pkg::IDX_OUT_W-1:0] idx;
    logic [fbpa_pkg::CNT_W-1:0]     nfree;
  } pool_res_t;

  typedef struct packed {
    logic                          kind;
    logic [fbpa_pkg::FIELD_AW-1:0] addr;
    logic                          hold;
    pool_res_t                     want;
  } pool_op_t;

  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            in_valid_i     = 1'b0;
  logic                            in_ready_o;
  logic                            kind_i         = fbpa_pkg::KIND_ALLOC;
  logic [fbpa_pkg::FIELD_AW-1:0]   free_address_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i    = 1'b0;
  logic                            status_o;
  logic [fbpa_pkg::FIELD_AW-1:0]   block_address_o;
  logic [fbpa_pkg::IDX_OUT_W-1:0]  block_index_o;
  logic [fbpa_pkg::CNT_W-1:0]      free_blocks_o;
  logic                            psel           = 1'b0;
  logic                            penable        = 1'b0;
  logic                            pwrite         = 1'b0;
  logic [fbpa_pkg::APB_ADDR_W-1:0] paddr          = '0;
  logic [fbpa_pkg::APB_DATA_W-1:0] pwdata         = '0;
  logic [fbpa_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  fixed_block_pool_allocator #(
    .DEPTH    (POOL_DEPTH),
    .ADDR_BITS(fbpa_pkg::FIELD_AW)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .free_address_i (free_address_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .block_address_o(block_address_o),
    .block_index_o  (block_index_o),
    .free_blocks_o  (free_blocks_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pool model: registers, embedded free list and counters.
  logic [fbpa_pkg::BSIZE_W-1:0]  cfg_bsize   = fbpa_pkg::BLK_BYTES_RST;
  logic [fbpa_pkg::CNT_W-1:0]    cfg_nblocks = fbpa_pkg::POOL_BLOCKS_RST;
  logic [fbpa_pkg::FIELD_AW-1:0] cfg_base    = '0;
  logic [fbpa_pkg::CNT_W-1:0]    next_blk [0:POOL_DEPTH-1];
  bit                            blk_touched [0:POOL_DEPTH-1];
  logic [fbpa_pkg::CNT_W-1:0]    free_head   = '0;
  logic [fbpa_pkg::CNT_W-1:0]    touched_cnt = '0;
  logic [fbpa_pkg::CNT_W-1:0]    free_cnt    = fbpa_pkg::POOL_BLOCKS_RST;

  pool_op_t                         pending_ops[$];
  pool_res_t                        owed_results[$];
  logic [fbpa_pkg::IDX_OUT_W-1:0]   held_blks[$];
  pool_res_t                        seen_want;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int cycles         = 0;
  int words_sent     = 0;
  int results_seen   = 0;
  int settings_run   = 0;
  int empty_allocs   = 0;
  int ignored_frees  = 0;

  function automatic logic [fbpa_pkg::CNT_W-1:0] pool_limit();
    return (cfg_nblocks < POOL_DEPTH) ? cfg_nblocks : fbpa_pkg::CNT_W'(POOL_DEPTH);
  endfunction

  function automatic logic [fbpa_pkg::FIELD_AW-1:0] bytes_per_blk();
    return (cfg_bsize == 0) ? fbpa_pkg::FIELD_AW'(1) : fbpa_pkg::FIELD_AW'(cfg_bsize);
  endfunction

  function automatic void cfg_update(input logic [fbpa_pkg::REG_IDX_W-1:0] reg_idx,
                                     input logic [fbpa_pkg::APB_DATA_W-1:0] v);
    case (reg_idx)
      fbpa_pkg::REG_BLK_BYTES: cfg_bsize = v[fbpa_pkg::BSIZE_W-1:0];
      fbpa_pkg::REG_POOL_BLOCKS: begin
        // Rewriting the pool size starts a fresh pool; stale links stay in memory.
        cfg_nblocks = v[fbpa_pkg::CNT_W-1:0];
        free_head   = '0;
        touched_cnt = '0;
        free_cnt    = pool_limit();
        held_blks.delete();
      end
      fbpa_pkg::REG_BASE_ADDRESS: cfg_base = v[fbpa_pkg::FIELD_AW-1:0];
      default: ;
    endcase
  endfunction

  function automatic pool_res_t apply_pool_op(input logic kind,
                                              input logic [fbpa_pkg::FIELD_AW-1:0] addr);
    pool_res_t                     r;
    logic [fbpa_pkg::CNT_W-1:0]    lim;
    logic [fbpa_pkg::FIELD_AW-1:0] size;
    logic [fbpa_pkg::FIELD_AW-1:0] blk;
    logic [fbpa_pkg::CNT_W-1:0]    got;
    r    = '0;
    lim  = pool_limit();
    size = bytes_per_blk();
    if (kind == fbpa_pkg::KIND_ALLOC) begin
      if (touched_cnt < lim) begin
        next_blk[BLK_IDX_W'(touched_cnt)]    = touched_cnt + fbpa_pkg::CNT_W'(1);
        blk_touched[BLK_IDX_W'(touched_cnt)] = 1'b1;
        touched_cnt                          = touched_cnt + fbpa_pkg::CNT_W'(1);
      end
      if (free_cnt > 0) begin
        got      = free_head;
        r.addr   = cfg_base + fbpa_pkg::FIELD_AW'(got) * size;
        r.idx    = got[fbpa_pkg::IDX_OUT_W-1:0];
        free_cnt = free_cnt - fbpa_pkg::CNT_W'(1);
        if (free_cnt == 0)
          free_head = lim;
        else
          free_head = (got < POOL_DEPTH) ? next_blk[BLK_IDX_W'(got)] : lim;
      end else begin
        r.status = fbpa_pkg::STATUS_EMPTY;
      end
    end else begin
      blk   = (addr - cfg_base) / size;
      r.idx = blk[fbpa_pkg::IDX_OUT_W-1:0];
      if (blk < fbpa_pkg::FIELD_AW'(lim) && free_cnt < lim) begin
        next_blk[BLK_IDX_W'(blk)]    = (free_cnt > 0) ? free_head : lim;
        blk_touched[BLK_IDX_W'(blk)] = 1'b1;
        free_head                    = blk[fbpa_pkg::CNT_W-1:0];
        free_cnt                     = free_cnt + fbpa_pkg::CNT_W'(1);
      end
    end
    r.nfree = free_cnt;
    return r;
  endfunction

  // An allocation that follows the head into a link never written is outside
  // what the block promises; only broken free sequences can lead there.
  function automatic bit alloc_reads_known();
    if (free_cnt <= 1 || free_head >= POOL_DEPTH)
      return 1'b1;
    return blk_touched[BLK_IDX_W'(free_head)] ||
           (touched_cnt < pool_limit() && free_head == touched_cnt);
  endfunction

  function automatic void queue_op(input logic kind,
                                   input logic [fbpa_pkg::FIELD_AW-1:0] addr,
                                   input bit hold);
    pool_op_t                   op;
    logic [fbpa_pkg::CNT_W-1:0] was_free;
    was_free = free_cnt;
    op.kind  = kind;
    op.addr  = addr;
    op.hold  = hold;
    op.want  = apply_pool_op(kind, addr);
    pending_ops.push_back(op);
    if (kind == fbpa_pkg::KIND_ALLOC) begin
      if (op.want.status == fbpa_pkg::STATUS_EMPTY)
        empty_allocs++;
      else
        held_blks.push_back(op.want.idx);
    end else if (op.want.nfree == was_free) begin
      ignored_frees++;
    end else begin
      for (int k = 0; k < held_blks.size(); k++) begin
        if (held_blks[k] == op.want.idx) begin
          held_blks.delete(k);
          break;
        end
      end
    end
  endfunction

  function automatic bit queue_random_op(input bit hold);
    int unsigned                   pick;
    int unsigned                   k;
    logic [fbpa_pkg::FIELD_AW-1:0] size;
    logic [fbpa_pkg::FIELD_AW-1:0] a;
    size = bytes_per_blk();
    pick = $urandom_range(99);
    if (pick < 50 || (pick < 85 && held_blks.size() == 0)) begin
      if (alloc_reads_known()) begin
        queue_op(fbpa_pkg::KIND_ALLOC, $urandom(), hold);
        return 1'b1;
      end
      // Repair the head with a free; a full pool leaves nothing to repair with.
      if (free_cnt >= pool_limit())
        return 1'b0;
      queue_op(fbpa_pkg::KIND_FREE, cfg_base + size * $urandom_range(pool_limit() - 1), hold);
      return 1'b1;
    end
    if (pick < 85) begin
      k = $urandom_range(held_blks.size() - 1);
      a = cfg_base + size * fbpa_pkg::FIELD_AW'(held_blks[k]) + $urandom_range(size - 1);
    end else begin
      case ($urandom_range(2))
        0: a = $urandom();
        1: a = cfg_base + size * (fbpa_pkg::FIELD_AW'(pool_limit()) + $urandom_range(3));
        default: a = cfg_base + size * $urandom_range(pool_limit() - 1);
      endcase
    end
    queue_op(fbpa_pkg::KIND_FREE, a, hold);
    return 1'b1;
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("tb: %s mismatch: expected %h, got %h", what, want, got);
  endfunction

  task automatic reg_write(input logic [fbpa_pkg::REG_IDX_W-1:0] reg_idx,
                           input logic [fbpa_pkg::APB_DATA_W-1:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_update(reg_idx, v);
  endtask

  task automatic reg_check(input logic [fbpa_pkg::REG_IDX_W-1:0] reg_idx,
                           input logic [fbpa_pkg::APB_DATA_W-1:0] want, input string what);
    logic [fbpa_pkg::APB_DATA_W-1:0] v;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    v = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (v !== want)
      note_mismatch(what, want, v);
  endtask

  task automatic set_pool(input logic [fbpa_pkg::APB_DATA_W-1:0] bs,
                          input logic [fbpa_pkg::APB_DATA_W-1:0] nb,
                          input logic [fbpa_pkg::APB_DATA_W-1:0] ba,
                          input int s_idle, input int r_stall);
    while (pending_ops.size() != 0 || owed_results.size() != 0)
      @(posedge clk_i);
    reg_write(fbpa_pkg::REG_BLK_BYTES, bs);
    reg_write(fbpa_pkg::REG_POOL_BLOCKS, nb);
    reg_write(fbpa_pkg::REG_BASE_ADDRESS, ba);
    reg_check(fbpa_pkg::REG_BLK_BYTES, fbpa_pkg::APB_DATA_W'(cfg_bsize), "block bytes read");
    reg_check(fbpa_pkg::REG_POOL_BLOCKS, fbpa_pkg::APB_DATA_W'(cfg_nblocks),
              "pool blocks read");
    reg_check(fbpa_pkg::REG_BASE_ADDRESS, cfg_base, "base address read");
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    settings_run++;
  endtask

  task automatic run_random(input int n_ops);
    for (int i = 0; i < n_ops; i++) begin
      if (!queue_random_op(i == n_ops / 2))
        break;
    end
  endtask

  // Sender: a word stays on the bus until taken; a held word waits for an idle block.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        owed_results.push_back(pending_ops[0].want);
        pending_ops.delete(0);
        words_sent++;
      end
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct &&
          !(pending_ops[0].hold && owed_results.size() != 0)) begin
        in_valid_i     <= 1'b1;
        kind_i         <= pending_ops[0].kind;
        free_address_i <= pending_ops[0].addr;
      end else begin
        in_valid_i     <= 1'b0;
        kind_i         <= 1'($urandom_range(1));
        free_address_i <= $urandom();
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          note_mismatch("unexpected result, index", '0, 32'(block_index_o));
        end else begin
          seen_want = owed_results.pop_front();
          if (status_o !== seen_want.status)
            note_mismatch("status", 32'(seen_want.status), 32'(status_o));
          if (block_address_o !== seen_want.addr)
            note_mismatch("block_address", seen_want.addr, block_address_o);
          if (block_index_o !== seen_want.idx)
            note_mismatch("block_index", 32'(seen_want.idx), 32'(block_index_o));
          if (free_blocks_o !== seen_want.nfree)
            note_mismatch("free_blocks", 32'(seen_want.nfree), 32'(free_blocks_o));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // A four-block pool whose base sits just below the top of the address space,
    // so handed-out addresses wrap through zero.
    set_pool(32'd16, 32'd4, 32'hFFFF_FFE0, 0, 0);
    repeat (4) queue_op(fbpa_pkg::KIND_ALLOC, '0, 1'b0);
    queue_op(fbpa_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 1'b0);   // empty pool
    queue_op(fbpa_pkg::KIND_FREE, 32'h0000_0000, 1'b0);
    queue_op(fbpa_pkg::KIND_FREE, 32'hFFFF_FFFF, 1'b0);    // last byte of a block
    queue_op(fbpa_pkg::KIND_FREE, 32'h0000_0040, 1'b0);    // index past the pool
    queue_op(fbpa_pkg::KIND_FREE, 32'hFFFF_FFDF, 1'b0);    // below the base, huge index
    queue_op(fbpa_pkg::KIND_FREE, 32'hFFFF_FFE5, 1'b0);
    queue_op(fbpa_pkg::KIND_FREE, 32'h0000_0010, 1'b0);
    queue_op(fbpa_pkg::KIND_FREE, 32'hFFFF_FFE0, 1'b0);    // pool already full
    repeat (5) queue_op(fbpa_pkg::KIND_ALLOC, 32'h5555_AAAA, 1'b0);
    queue_op(fbpa_pkg::KIND_FREE, 32'hFFFF_FFF0, 1'b0);
    queue_op(fbpa_pkg::KIND_ALLOC, '0, 1'b0);

    set_pool(32'd64, 32'd1024, 32'h0000_0000, 0, 0);
    run_random(75);
    set_pool(32'd1, 32'd1, 32'hFFFF_FFFF, 52, 0);
    run_random(75);
    set_pool(32'd65536, 32'd8, 32'h8000_0000, 0, 52);
    run_random(75);
    set_pool(32'd0, 32'd16, 32'h1234_5678, 35, 35);
    run_random(75);
    set_pool(32'd3, 32'd1024, 32'hFFFF_0000, 0, 0);
    run_random(75);
    set_pool(32'd4096, 32'd5, 32'h0000_0000, 52, 0);
    run_random(75);
    set_pool(32'd7, 32'd32, $urandom(), 0, 52);
    run_random(75);
    set_pool(32'd65536, 32'd1024, 32'hFFFF_FFFF, 35, 35);
    run_random(75);

    while (pending_ops.size() != 0 || owed_results.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("tb: %0d words sent and %0d results compared across %0d register settings",
             words_sent, results_seen, settings_run);
    $display("tb: %0d allocations met an empty pool, %0d frees were ignored",
             empty_allocs, ignored_frees);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
